// ===== design/gmnt_pkg.sv =====
// Shared constants, register codes and sequencer states for the grid normal/tangent block.
package gmnt_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_COORD_BITS = 24;

  localparam int NRM_BITS  = 16;
  localparam int NRM_MAX   = 32767;
  localparam int GW_BITS   = 10;
  localparam int GH_BITS   = 13;
  localparam int CFG_BITS  = 13;
  localparam int GW_RESET  = 256;
  localparam int GH_RESET  = 256;

  // normalization datapath: scaled magnitudes, sum of squares, quotient, root
  localparam int A_BITS = 30;
  localparam int S_BITS = 62;
  localparam int Q_BITS = 33;
  localparam int R_BITS = 17;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_MUL,
    S_CRS,
    S_NRM,
    S_SQ,
    S_DIVA,
    S_DIVB,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

endpackage

// ===== design/gmnt_if.sv =====
// Valid/ready channel interfaces for vertex items and result items.
interface gmnt_in_if #(parameter int COORD_BITS = gmnt_pkg::DEF_COORD_BITS);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, kind, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, output ready);
endinterface

interface gmnt_out_if #(parameter int COORD_BITS = gmnt_pkg::DEF_COORD_BITS);
  logic                                    valid;
  logic                                    ready;
  logic signed [gmnt_pkg::NRM_BITS-1:0]    normal_x;
  logic signed [gmnt_pkg::NRM_BITS-1:0]    normal_y;
  logic signed [gmnt_pkg::NRM_BITS-1:0]    normal_z;
  logic signed [COORD_BITS+1:0]            tan_x;
  logic signed [COORD_BITS+1:0]            tan_y;
  logic signed [COORD_BITS+1:0]            tan_z;
  logic                                    last;

  modport source (output valid, normal_x, normal_y, normal_z, tan_x, tan_y, tan_z,
                  last, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, tan_x, tan_y, tan_z,
                  last, output ready);
endinterface

// ===== design/grid_mesh_normal_tangent_top.sv =====
// Grid mesh normal/tangent unit: line stores in RAM, sequenced tangent, cross and normalize.
//
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | kind, pos_x, pos_y, pos_z
//  out_ch  | out | valid/ready       | normal_x/y/z, tan_x/y/z, last
//  cfg     | in  | cfg_we            | cfg_idx, cfg_data
//
// A vertex in row 0 runs only the store read states; a flush outside the last row starts nothing.
// A computing item runs the store read states S_RD0 to S_RD3, up to 21 normalize shifts, and
// per component a 33-step divider and a 17-step root loop; a zero cross product skips both.
// Results appear one item late: a computed result is held until the next item arrives.
// rst_n is synchronous; line stores are not cleared. in_ch stalls while busy or
// while a held result waits behind an untaken output beat.
module grid_mesh_normal_tangent_top #(
  parameter int MAX_WIDTH  = gmnt_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gmnt_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_BITS = gmnt_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gmnt_in_if.sink                        in_ch,
  gmnt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  gmnt_pkg::cfg_reg_t             cfg_idx,
  input  logic [gmnt_pkg::CFG_BITS-1:0]  cfg_data
);

  import gmnt_pkg::*;

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int TB = COORD_BITS + 2;
  localparam int K  = (COORD_BITS > 28) ? COORD_BITS - 28 : 0;
  localparam int AW = TB - K;
  localparam int PW = 2 * AW;
  localparam int CW = PW + 1;
  localparam int MW = (CW > 31) ? CW : 31;
  localparam int DW = 3 * COORD_BITS;

  // ---------------------------------------------------------------- config
  logic [GW_BITS-1:0] gw_r;
  logic [GH_BITS-1:0] gh_r;
  logic [WB-1:0]      w_eff;
  logic [HB-1:0]      h_eff;

  always_comb begin
    if (gw_r < GW_BITS'(2)) begin
      w_eff = WB'(2);
    end else if (32'(gw_r) > 32'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(gw_r);
    end
    if (gh_r < GH_BITS'(2)) begin
      h_eff = HB'(2);
    end else if (32'(gh_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HB'(MAX_HEIGHT);
    end else begin
      h_eff = HB'(gh_r);
    end
  end

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  logic [CB-1:0] col_r;
  logic [RB-1:0] row_r;
  logic [HB-1:0] orow_r;
  logic [CB-1:0] ocol_r;

  // vertices of row 0 only shift the stores; row 1 has no upper neighbor but computes
  logic calc_r;

  logic                         flush_r;
  logic [CB-1:0]                c_r;
  logic                         has_l_r, has_r_r, has_up_r, last_r;
  logic signed [COORD_BITS-1:0] p_r [3];

  logic [DW-1:0] mid_c_r, up_c_r, mid_n_r, up_l_r;
  logic [DW-1:0] mid_rd, up_rd;

  logic signed [AW-1:0] a_r [3];
  logic signed [AW-1:0] b_r [3];
  logic signed [TB-1:0] ty_r [3];
  logic signed [PW-1:0] prod_r [6];
  logic [MW-1:0]        m_r [3];
  logic                 sgn_r [3];

  logic [1:0]          comp_r;
  logic [4:0]          cnt_r;
  logic [S_BITS-1:0]   sq_r, s_sum_r, rem_r;
  logic [Q_BITS-1:0]   quo_r;
  logic [R_BITS-1:0]   root_r;
  logic signed [NRM_BITS-1:0] nrm_r [3];

  logic                       held_valid_r;
  logic signed [NRM_BITS-1:0] hn_r [3];
  logic signed [TB-1:0]       ht_r [3];
  logic                       hl_r;

  logic                       out_valid_r;
  logic signed [NRM_BITS-1:0] on_r [3];
  logic signed [TB-1:0]       ot_r [3];
  logic                       ol_r;

  // ---------------------------------------------------------------- accept
  logic in_acc, out_acc;
  assign in_ch.ready = (state_r == S_IDLE) && !(held_valid_r && out_valid_r);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;

  logic          acc_calc, acc_go, acc_last, acc_has_l, acc_has_r, acc_has_up;
  logic [CB-1:0] acc_col, col_nxt, ocol_nxt;
  logic [RB-1:0] row_nxt;
  logic [HB-1:0] orow_nxt;
  logic [CB-1:0] c_in;
  logic [WB-1:0] c_plus;
  logic          row_end;

  always_comb begin
    acc_calc   = 1'b0;
    acc_go     = 1'b0;
    acc_last   = 1'b0;
    acc_has_up = 1'b1;
    col_nxt    = col_r;
    row_nxt    = row_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    if (in_ch.kind == KIND_FLUSH) begin
      c_in     = ocol_r;
      c_plus   = WB'(ocol_r) + WB'(1);
      row_end  = (c_plus == w_eff);
      acc_calc = (orow_r == h_eff - HB'(1));
      acc_go   = acc_calc;
      acc_last = row_end;
      if (acc_calc) begin
        if (row_end) begin
          orow_nxt = orow_r + HB'(1);
          ocol_nxt = '0;
        end else begin
          ocol_nxt = c_plus[CB-1:0];
        end
      end
    end else begin
      c_in       = (WB'(col_r) >= w_eff) ? '0 : col_r;
      c_plus     = WB'(c_in) + WB'(1);
      row_end    = (c_plus == w_eff);
      acc_calc   = (row_r != '0);
      acc_go     = 1'b1;
      acc_has_up = (row_r >= RB'(2));
      if (acc_calc) begin
        orow_nxt = row_end ? HB'(row_r) : HB'(row_r) - HB'(1);
        ocol_nxt = row_end ? '0 : c_plus[CB-1:0];
      end else begin
        orow_nxt = '0;
        ocol_nxt = '0;
      end
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (HB'(row_r) + HB'(1) >= h_eff) ? '0 : row_r + RB'(1);
      end else begin
        col_nxt = c_plus[CB-1:0];
      end
    end
    acc_col   = c_in;
    acc_has_l = (c_in != '0);
    acc_has_r = !row_end;
  end

  // ---------------------------------------------------------------- line stores
  logic          up_we, mid_we;
  logic [CB-1:0] up_raddr, mid_raddr;
  logic [DW-1:0] up_wdata, mid_wdata;

  always_comb begin
    up_we     = 1'b0;
    mid_we    = 1'b0;
    up_raddr  = c_r;
    mid_raddr = c_r;
    up_wdata  = mid_c_r;
    mid_wdata = {p_r[2], p_r[1], p_r[0]};
    unique case (state_r)
      S_RD1: begin
        mid_raddr = c_r + CB'(1);
        up_raddr  = c_r - CB'(1);
      end
      S_RD2: begin
        mid_raddr = c_r - CB'(1);
        up_we     = (flush_r == KIND_VERTEX);
        mid_we    = (flush_r == KIND_VERTEX);
      end
      default: ;
    endcase
  end

  gmnt_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk   (clk),
    .we    (up_we),
    .waddr (c_r),
    .wdata (up_wdata),
    .raddr (up_raddr),
    .rdata (up_rd)
  );

  gmnt_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk   (clk),
    .we    (mid_we),
    .waddr (c_r),
    .wdata (mid_wdata),
    .raddr (mid_raddr),
    .rdata (mid_rd)
  );

  // ---------------------------------------------------------------- tangents
  function automatic logic signed [COORD_BITS-1:0] crd(input logic [DW-1:0] wd, input int i);
    return wd[i*COORD_BITS +: COORD_BITS];
  endfunction

  function automatic logic signed [AW-1:0] trunc_k(input logic signed [TB-1:0] v);
    logic [TB-1:0] mg;
    logic [TB-1:0] sh;
    logic [AW-1:0] m2;
    mg = v[TB-1] ? TB'(-v) : TB'(v);
    sh = mg >> K;
    m2 = sh[AW-1:0];
    return v[TB-1] ? AW'(AW'(0) - m2) : m2;
  endfunction

  logic signed [TB-1:0] tx_c [3];
  logic signed [TB-1:0] ty_c [3];
  logic [DW-1:0]        lf_w;

  always_comb begin
    logic signed [COORD_BITS-1:0] ct, lf, rt, up, dn;
    logic signed [TB-1:0] d0, d1, d2, d3;
    lf_w = (flush_r == KIND_FLUSH) ? mid_rd : up_l_r;
    for (int k = 0; k < 3; k++) begin
      ct = crd(mid_c_r, k);
      lf = crd(lf_w, k);
      rt = crd(mid_n_r, k);
      up = crd(up_c_r, k);
      dn = p_r[k];
      d0 = has_l_r  ? TB'(ct) - TB'(lf) : '0;
      d1 = has_r_r  ? TB'(rt) - TB'(ct) : '0;
      d2 = has_up_r ? TB'(ct) - TB'(up) : '0;
      d3 = (flush_r == KIND_VERTEX) ? TB'(dn) - TB'(ct) : '0;
      tx_c[k] = d0 + d1;
      ty_c[k] = d2 + d3;
    end
  end

  // ---------------------------------------------------------------- normalize helpers
  logic signed [CW-1:0] cr_c [3];
  always_comb begin
    cr_c[0] = CW'(prod_r[0]) - CW'(prod_r[1]);
    cr_c[1] = CW'(prod_r[2]) - CW'(prod_r[3]);
    cr_c[2] = CW'(prod_r[4]) - CW'(prod_r[5]);
  end

  logic              big;
  logic [A_BITS-1:0] msel;
  logic [S_BITS-1:0] sq_c, s_total;

  assign big = (|(m_r[0] >> A_BITS)) || (|(m_r[1] >> A_BITS)) || (|(m_r[2] >> A_BITS));

  always_comb begin
    case (comp_r)
      2'd0:    msel = m_r[0][A_BITS-1:0];
      2'd1:    msel = m_r[1][A_BITS-1:0];
      2'd2:    msel = m_r[2][A_BITS-1:0];
      default: msel = '0;
    endcase
  end

  assign sq_c    = S_BITS'(msel) * S_BITS'(msel);
  assign s_total = s_sum_r + sq_r;

  logic [S_BITS:0]   dshift;
  logic              dge;
  logic [S_BITS-1:0] rem_nxt;
  assign dshift  = {rem_r, 1'b0};
  assign dge     = dshift >= (S_BITS + 1)'(s_sum_r);
  assign rem_nxt = dge ? S_BITS'(dshift - (S_BITS + 1)'(s_sum_r)) : S_BITS'(dshift);

  logic [R_BITS-1:0]   cand, root_nxt;
  logic [2*R_BITS-1:0] cand_sq;
  logic [R_BITS:0]     qh;
  logic [NRM_BITS-2:0] qmag;
  logic signed [NRM_BITS-1:0] nval;

  always_comb begin
    cand     = root_r | (R_BITS'(1) << cnt_r);
    cand_sq  = (2*R_BITS)'(cand) * (2*R_BITS)'(cand);
    root_nxt = (cand_sq <= (2*R_BITS)'(quo_r)) ? cand : root_r;
    qh       = ((R_BITS + 1)'(root_nxt) + (R_BITS + 1)'(1)) >> 1;
    qmag     = (qh > (R_BITS + 1)'(NRM_MAX)) ? (NRM_BITS - 1)'(NRM_MAX) : qh[NRM_BITS-2:0];
    nval     = sgn_r[comp_r] ? NRM_BITS'(NRM_BITS'(0) - {1'b0, qmag}) : {1'b0, qmag};
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && acc_go) state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = calc_r ? S_RD3 : S_IDLE;
      S_RD3:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CRS;
      S_CRS:  state_nxt = S_NRM;
      S_NRM:  if (!big) state_nxt = S_SQ;
      S_SQ:   if (comp_r == 2'd3) state_nxt = (s_total == '0) ? S_DONE : S_DIVA;
      S_DIVA: state_nxt = S_DIVB;
      S_DIVB: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 5'd31) state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == '0) state_nxt = (comp_r == 2'd2) ? S_DONE : S_DIVA;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gw_r         <= GW_BITS'(GW_RESET);
      gh_r         <= GH_BITS'(GH_RESET);
      col_r        <= '0;
      row_r        <= '0;
      orow_r       <= '0;
      ocol_r       <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      calc_r       <= 1'b0;
      comp_r       <= '0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (out_acc) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        // move the held result to the output beat
        if (held_valid_r) begin
          out_valid_r  <= 1'b1;
          held_valid_r <= 1'b0;
          on_r         <= hn_r;
          ot_r         <= ht_r;
          ol_r         <= hl_r;
        end
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        orow_r   <= orow_nxt;
        ocol_r   <= ocol_nxt;
        flush_r  <= in_ch.kind;
        calc_r   <= acc_calc;
        c_r      <= acc_col;
        has_l_r  <= acc_has_l;
        has_r_r  <= acc_has_r;
        has_up_r <= acc_has_up;
        last_r   <= acc_last;
        p_r[0]   <= in_ch.pos_x;
        p_r[1]   <= in_ch.pos_y;
        p_r[2]   <= in_ch.pos_z;
      end

      unique case (state_r)
        S_RD1: begin
          mid_c_r <= mid_rd;
          up_c_r  <= up_rd;
        end
        S_RD2: begin
          mid_n_r <= mid_rd;
          up_l_r  <= up_rd;
        end
        S_RD3: begin
          for (int k = 0; k < 3; k++) begin
            a_r[k]  <= trunc_k(tx_c[k]);
            b_r[k]  <= trunc_k(ty_c[k]);
            ty_r[k] <= ty_c[k];
          end
        end
        S_MUL: begin
          prod_r[0] <= PW'(a_r[1]) * PW'(b_r[2]);
          prod_r[1] <= PW'(a_r[2]) * PW'(b_r[1]);
          prod_r[2] <= PW'(a_r[2]) * PW'(b_r[0]);
          prod_r[3] <= PW'(a_r[0]) * PW'(b_r[2]);
          prod_r[4] <= PW'(a_r[0]) * PW'(b_r[1]);
          prod_r[5] <= PW'(a_r[1]) * PW'(b_r[0]);
          for (int k = 0; k < 3; k++) begin
            nrm_r[k] <= '0;
          end
        end
        S_CRS: begin
          for (int k = 0; k < 3; k++) begin
            m_r[k]   <= MW'(cr_c[k][CW-1] ? -cr_c[k] : cr_c[k]);
            sgn_r[k] <= cr_c[k][CW-1];
          end
          comp_r  <= '0;
          s_sum_r <= '0;
        end
        S_NRM: begin
          if (big) begin
            for (int k = 0; k < 3; k++) begin
              m_r[k] <= m_r[k] >> 1;
            end
          end
        end
        S_SQ: begin
          sq_r   <= sq_c;
          comp_r <= comp_r + 2'd1;
          if (comp_r != '0) begin
            s_sum_r <= s_total;
          end
        end
        S_DIVA: begin
          sq_r <= sq_c;
        end
        S_DIVB: begin
          if (sq_r >= s_sum_r) begin
            quo_r <= Q_BITS'(1);
            rem_r <= sq_r - s_sum_r;
          end else begin
            quo_r <= '0;
            rem_r <= sq_r;
          end
          cnt_r <= '0;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[Q_BITS-2:0], dge};
          if (cnt_r == 5'd31) begin
            root_r <= '0;
            cnt_r  <= 5'(R_BITS - 1);
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQRT: begin
          root_r <= root_nxt;
          cnt_r  <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            nrm_r[comp_r] <= nval;
            comp_r        <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
          end
        end
        S_DONE: begin
          held_valid_r <= 1'b1;
          hn_r         <= nrm_r;
          ht_r         <= ty_r;
          hl_r         <= last_r;
        end
        default: ;
      endcase

      // a register write restarts the grid and drops the held result
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_GRID_WIDTH:  gw_r <= cfg_data[GW_BITS-1:0];
          REG_GRID_HEIGHT: gh_r <= cfg_data[GH_BITS-1:0];
          default: ;
        endcase
        col_r        <= '0;
        row_r        <= '0;
        orow_r       <= '0;
        ocol_r       <= '0;
        held_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_ch.valid    = out_valid_r;
  assign out_ch.normal_x = on_r[0];
  assign out_ch.normal_y = on_r[1];
  assign out_ch.normal_z = on_r[2];
  assign out_ch.tan_x    = ot_r[0];
  assign out_ch.tan_y    = ot_r[1];
  assign out_ch.tan_z    = ot_r[2];
  assign out_ch.last     = ol_r;

  // ---------------------------------------------------------------- checks
  a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < s_sum_r)
    else $error("divider remainder not below divisor");

  a_cfg_drops_held: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !held_valid_r)
    else $error("held result survived a register write");

  a_held_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && held_valid_r && !cfg_we) |=> out_valid_r && !held_valid_r)
    else $error("held result not moved to output beat");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !cfg_we) |=> held_valid_r && state_r == S_IDLE)
    else $error("finished result not held");

  a_calc_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD3 |-> calc_r)
    else $error("tangent stage entered for an item that computes nothing");

endmodule

// ===== design/gmnt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gmnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AB = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AB-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AB-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
